// ===== design/bsfb_pkg.sv =====
// ----------------------------------------------------------------------------
// bsfb_pkg: shared types and constants of the byte-stuffed frame builder
// Mode codes, framing bytes, the command passed from front to back end and
// helpers for the emit sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package bsfb_pkg;

  localparam logic [1:0] MODE_DATA  = 2'd0;
  localparam logic [1:0] MODE_FINAL = 2'd1;
  localparam logic [1:0] MODE_CLOSE = 2'd2;
  localparam logic [1:0] MODE_CTRL  = 2'd3;

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_FLAG  = 8'h5E;
  localparam logic [7:0] ESC_ESC   = 8'h5D;
  localparam int unsigned SEQ_SHIFT = 6;

  localparam int unsigned NSTEP = 9;

  // Emit steps, in output order
  typedef enum logic [NSTEP-1:0] {
    ST_HFLAG = 9'b0_0000_0001,
    ST_HADDR = 9'b0_0000_0010,
    ST_HCTL  = 9'b0_0000_0100,
    ST_HBCC  = 9'b0_0000_1000,
    ST_DAT0  = 9'b0_0001_0000,
    ST_DAT1  = 9'b0_0010_0000,
    ST_BCC0  = 9'b0_0100_0000,
    ST_BCC1  = 9'b0_1000_0000,
    ST_FLAG  = 9'b1_0000_0000
  } step_t;

  typedef struct packed {
    logic       do_hdr;
    logic [7:0] addr;
    logic [7:0] ctl;
    logic       do_data;
    logic [7:0] data;
    logic       do_bcc;
    logic [7:0] bcc;
    logic       do_flag;
  } cmd_t;

  function automatic logic needs_esc(input logic [7:0] b);
    return (b == FLAG_BYTE) || (b == ESC_BYTE);
  endfunction

  function automatic logic [7:0] esc_code(input logic [7:0] b);
    return (b == FLAG_BYTE) ? ESC_FLAG : ESC_ESC;
  endfunction

  // Steps this command emits, one bit per step_t code
  function automatic logic [NSTEP-1:0] cmd_steps(input cmd_t c);
    logic [NSTEP-1:0] en;
    en    = '0;
    en[0] = c.do_hdr;
    en[1] = c.do_hdr;
    en[2] = c.do_hdr;
    en[3] = c.do_hdr;
    en[4] = c.do_data;
    en[5] = c.do_data && needs_esc(c.data);
    en[6] = c.do_bcc;
    en[7] = c.do_bcc && needs_esc(c.bcc);
    en[8] = c.do_flag;
    return en;
  endfunction

  function automatic logic [NSTEP-1:0] lowest_bit(input logic [NSTEP-1:0] v);
    return v & (~v + {{(NSTEP-1){1'b0}}, 1'b1});
  endfunction

endpackage

`default_nettype wire

// ===== design/byte_stuffed_frame_builder.sv =====
// ----------------------------------------------------------------------------
// byte_stuffed_frame_builder: link-layer framer with byte stuffing
// Builds information frames (header, stuffed payload, stuffed BCC2, flag)
// and five-byte control frames from a stream of byte commands.
// ----------------------------------------------------------------------------
// Path: input -> command queue -> sequencer command register -> output register.
// Throughput: one output byte per cycle while out_stall allows; an input
//   causes 1 to 9 output bytes (two for an escaped payload or BCC2 byte).
//   The input side accepts while the two-entry command queue has room.
// Reset: synchronous active-low rst_n closes any open frame, clears BCC2,
//   empties the queue and drops out_valid.
`default_nettype none

module byte_stuffed_frame_builder
  import bsfb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_mode,
  input  wire logic [7:0] in_data_byte,
  input  wire logic [7:0] in_address,
  input  wire logic       in_seq_num,
  input  wire logic [7:0] in_control_field,
  // result channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_frame_end,
  output logic            out_run_last
);

  // Front end: frame state (open flag, running BCC2) updates at the input
  // transfer, so later inputs classify without waiting on the output side.
  logic q_full;
  logic q_nonempty;
  logic q_pop;
  logic in_take;
  cmd_t front_cmd;
  cmd_t q_head;

  assign in_stall = q_full;
  assign in_take  = in_valid && !q_full;

  bsfb_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .take          (in_take),
    .mode          (in_mode),
    .data_byte     (in_data_byte),
    .address       (in_address),
    .seq_num       (in_seq_num),
    .control_field (in_control_field),
    .cmd           (front_cmd)
  );

  // Short queue of emit commands between classifier and sequencer
  bsfb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_take),
    .push_cmd (front_cmd),
    .pop      (q_pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .head     (q_head)
  );

  // Back end: one byte per cycle into a registered output while out_stall allows;
  // the next command is loaded on the cycle its predecessor's last byte goes out.
  bsfb_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_nonempty    (q_nonempty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_frame_end (out_frame_end),
    .out_run_last  (out_run_last)
  );

endmodule

`default_nettype wire

// ===== design/bsfb_front.sv =====
// ----------------------------------------------------------------------------
// bsfb_front: input classifier
// Tracks the open frame and running BCC2, turns each input into an emit
// command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bsfb_front
  import bsfb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       take,
  input  wire logic [1:0] mode,
  input  wire logic [7:0] data_byte,
  input  wire logic [7:0] address,
  input  wire logic       seq_num,
  input  wire logic [7:0] control_field,
  output cmd_t            cmd
);

  logic       open_r, open_nxt;
  logic [7:0] par_r, par_nxt;
  logic [7:0] par_base;
  logic [7:0] par_upd;

  assign par_base = open_r ? par_r : 8'h00;
  assign par_upd  = par_base ^ ((mode != MODE_CLOSE) ? data_byte : 8'h00);

  always_comb begin
    cmd.addr    = address;
    cmd.data    = data_byte;
    cmd.bcc     = par_upd;
    cmd.do_flag = 1'b1;
    open_nxt    = open_r;
    par_nxt     = par_r;
    if (mode == MODE_CTRL) begin
      cmd.do_hdr  = 1'b1;
      cmd.ctl     = control_field;
      cmd.do_data = 1'b0;
      cmd.do_bcc  = 1'b0;
      open_nxt    = 1'b0;
      par_nxt     = 8'h00;
    end else begin
      cmd.do_hdr  = !open_r;
      cmd.ctl     = 8'(seq_num) << SEQ_SHIFT;
      cmd.do_data = (mode != MODE_CLOSE);
      cmd.do_bcc  = (mode != MODE_DATA);
      cmd.do_flag = (mode != MODE_DATA);
      open_nxt    = (mode == MODE_DATA);
      par_nxt     = (mode == MODE_DATA) ? par_upd : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      par_r  <= 8'h00;
    end else if (take) begin
      open_r <= open_nxt;
      par_r  <= par_nxt;
    end
  end

  // final payload byte always closes the frame
  a_final_closes: assert property (@(posedge clk) disable iff (!rst_n)
    take && (mode == MODE_FINAL) |=> !open_r)
    else $error("frame still open after final byte");

  a_par_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !open_r |-> par_r == 8'h00)
    else $error("BCC2 accumulator nonzero with no frame open");

  a_final_steps: assert property (@(posedge clk) disable iff (!rst_n)
    take && (mode == MODE_FINAL) |-> cmd.do_data && cmd.do_bcc && cmd.do_flag)
    else $error("final byte command incomplete");

endmodule

`default_nettype wire

// ===== design/bsfb_queue.sv =====
// ----------------------------------------------------------------------------
// bsfb_queue: two-entry command queue
// Decouples the classifier from the byte sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module bsfb_queue
  import bsfb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output logic      full,
  output logic      nonempty,
  output cmd_t      head
);

  cmd_t       ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign nonempty = (cnt_r != 2'd0);
  assign head     = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full || pop)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> nonempty)
    else $error("pop from empty queue");

  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1) |-> (wr_ptr_r != rd_ptr_r))
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ===== design/bsfb_back.sv =====
// ----------------------------------------------------------------------------
// bsfb_back: byte sequencer
// Walks the steps of one command, one byte per cycle while out_stall allows,
// into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bsfb_back
  import bsfb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_nonempty,
  input  wire cmd_t       q_head,
  output logic            q_pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_frame_end,
  output logic            out_run_last
);

  cmd_t             cur_r, cur_nxt;
  logic             cur_vld_r, cur_vld_nxt;
  step_t            step_r, step_nxt;
  logic             ov_r, ov_nxt;
  logic [7:0]       ob_r;
  logic             oend_r;
  logic             olast_r;

  logic [NSTEP-1:0] cur_en;
  logic [NSTEP-1:0] rem;
  logic             last;
  logic             emit;
  logic             load;
  logic [7:0]       byte_sel;

  assign cur_en = cmd_steps(cur_r);
  // steps still enabled after the current one
  assign rem    = cur_en & ~(step_r | (step_r - {{(NSTEP-1){1'b0}}, 1'b1}));
  assign last   = (rem == '0);
  assign emit   = cur_vld_r && (!ov_r || !out_stall);
  assign load   = q_nonempty && (!cur_vld_r || (emit && last));
  assign q_pop  = load;

  always_comb begin
    case (step_r)
      ST_HFLAG: byte_sel = FLAG_BYTE;
      ST_HADDR: byte_sel = cur_r.addr;
      ST_HCTL:  byte_sel = cur_r.ctl;
      ST_HBCC:  byte_sel = cur_r.addr ^ cur_r.ctl;
      ST_DAT0:  byte_sel = needs_esc(cur_r.data) ? ESC_BYTE : cur_r.data;
      ST_DAT1:  byte_sel = esc_code(cur_r.data);
      ST_BCC0:  byte_sel = needs_esc(cur_r.bcc) ? ESC_BYTE : cur_r.bcc;
      ST_BCC1:  byte_sel = esc_code(cur_r.bcc);
      ST_FLAG:  byte_sel = FLAG_BYTE;
      default:  byte_sel = FLAG_BYTE;
    endcase
  end

  always_comb begin
    cur_nxt     = cur_r;
    cur_vld_nxt = cur_vld_r;
    step_nxt    = step_r;
    if (load) begin
      cur_nxt     = q_head;
      cur_vld_nxt = 1'b1;
      step_nxt    = step_t'(lowest_bit(cmd_steps(q_head)));
    end else if (emit) begin
      if (last) begin
        cur_vld_nxt = 1'b0;
      end else begin
        step_nxt = step_t'(lowest_bit(rem));
      end
    end
    ov_nxt = emit ? 1'b1 : (ov_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      step_r    <= ST_HFLAG;
      ov_r      <= 1'b0;
    end else begin
      cur_vld_r <= cur_vld_nxt;
      step_r    <= step_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (emit) begin
      ob_r    <= byte_sel;
      oend_r  <= (step_r == ST_FLAG);
      olast_r <= last;
    end
  end

  assign out_valid     = ov_r;
  assign out_byte      = ob_r;
  assign out_frame_end = oend_r;
  assign out_run_last  = olast_r;

  a_end_is_flag: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && oend_r |-> (ob_r == FLAG_BYTE) && olast_r)
    else $error("frame end not on a closing flag");

  a_step_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    cur_vld_r |-> (cur_en & step_r) != '0)
    else $error("sequencer on a step the command does not use");

  a_step_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(step_r))
    else $error("step register not one-hot");

endmodule

`default_nettype wire
